// ===== rtl/core/fst_pkg.sv =====
package fst_pkg;

	// counter width default for line, column and token length
	localparam int COUNTER_BITS_DEF = 32;

	// configuration port
	localparam int ADDR_W = 3;
	localparam logic REG_ALPHABET = 1'b0;
	localparam logic ALPHA_DNA = 1'b0;
	localparam logic ALPHA_PROTEIN = 1'b1;

	// characters of interest
	localparam logic [7:0] CHR_GT = 8'h3E;
	localparam logic [7:0] CHR_LF = 8'h0A;
	localparam logic [7:0] CHR_TAB = 8'h09;
	localparam logic [7:0] CHR_CR = 8'h0D;
	localparam logic [7:0] CHR_SPACE = 8'h20;
	localparam logic [7:0] CHR_DASH = 8'h2D;
	localparam logic [7:0] CHR_UPPER_A = 8'h41;
	localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHR_LOWER_A = 8'h61;
	localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// letter masks indexed by letter minus 'A'
	localparam logic [25:0] DNA_MASK = 26'b01_1110_1110_0011_0100_1100_1111;
	localparam logic [25:0] PROTEIN_MASK = 26'b11_1111_1111_1011_1101_1111_1111;

	// parse phases
	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_LABEL = 3'd1;
	localparam logic [2:0] PH_COMMENT = 3'd2;
	localparam logic [2:0] PH_SEQ = 3'd3;
	localparam logic [2:0] PH_ERR_LABEL = 3'd4;
	localparam logic [2:0] PH_ERR_SEQ = 3'd5;
	localparam logic [2:0] PH_ERR_CHAR = 3'd6;

	// event kinds
	localparam logic [1:0] EV_TOKEN_BYTE = 2'd0;
	localparam logic [1:0] EV_TOKEN_DONE = 2'd1;
	localparam logic [1:0] EV_SYNTAX_ERR = 2'd2;
	localparam logic [1:0] EV_PARSE_DONE = 2'd3;

	// token kinds
	localparam logic [1:0] TK_LABEL = 2'd0;
	localparam logic [1:0] TK_COMMENT = 2'd1;
	localparam logic [1:0] TK_SEQ = 2'd2;

	// error codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_EMPTY_LABEL = 2'd1;
	localparam logic [1:0] ERR_NO_SEQ = 2'd2;
	localparam logic [1:0] ERR_BAD_CHAR = 2'd3;

	// byte classification handed from classifier to parser
	typedef struct packed {
		logic is_gt;
		logic is_lf;
		logic is_blank;
		logic is_seq_ws;
		logic letter_ok;
	} byte_class_t;

	// one result item
	typedef struct packed {
		logic [31:0] column_number;
		logic [31:0] line_number;
		logic [1:0]  error_code;
		logic [31:0] token_length;
		logic [7:0]  token_byte;
		logic [1:0]  token_kind;
		logic [1:0]  event_kind;
	} result_t;

endpackage

// ===== rtl/core/fst_class.sv =====
module fst_class
	import fst_pkg::*;
(
	input  logic [7:0]  in_byte,
	input  logic        alphabet_select,
	output byte_class_t cls
);

	logic [7:0] upper;
	logic       is_alpha;
	logic [4:0] letter_idx;
	logic [25:0] mask;

	// fold lower case onto upper case
	always_comb begin
		if (in_byte >= CHR_LOWER_A && in_byte <= CHR_LOWER_Z) begin
			upper = in_byte - CASE_OFFSET;
		end else begin
			upper = in_byte;
		end
	end

	assign is_alpha = (upper >= CHR_UPPER_A) && (upper <= CHR_UPPER_Z);
	assign letter_idx = 5'(upper - CHR_UPPER_A);
	assign mask = (alphabet_select == ALPHA_PROTEIN) ? PROTEIN_MASK : DNA_MASK;

	// class flags
	assign cls.is_gt = (in_byte == CHR_GT);
	assign cls.is_lf = (in_byte == CHR_LF);
	assign cls.is_blank = (in_byte == CHR_SPACE) || (in_byte == CHR_TAB);
	assign cls.is_seq_ws = (in_byte == CHR_SPACE) || (in_byte == CHR_TAB) ||
		(in_byte == CHR_LF) || (in_byte == CHR_CR);
	assign cls.letter_ok = (in_byte == CHR_DASH) || (is_alpha && mask[letter_idx]);

endmodule

// ===== rtl/core/fst_core.sv =====
module fst_core
	import fst_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  in_byte,
	input  logic        end_of_input,
	input  byte_class_t cls,
	output logic        emit,
	output result_t     res
);

	localparam int CW = COUNTER_BITS;
	localparam logic [CW-1:0] ONE = {{(CW-1){1'b0}}, 1'b1};

	logic [2:0]    phase_q, phase_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] line_q, line_d;
	logic [CW-1:0] col_q, col_d;
	logic [CW-1:0] count_inc, line_inc, col_inc;
	logic [31:0]   count_o, line_o, col_o;
	logic          col_zero;
	logic          rec_start;

	// saturating increments
	assign count_inc = (&count_q) ? count_q : count_q + ONE;
	assign line_inc = (&line_q) ? line_q : line_q + ONE;
	assign col_inc = (&col_q) ? col_q : col_q + ONE;
	assign col_zero = (col_q == '0);
	assign rec_start = cls.is_gt && col_zero;

	// clamp counters to the 32 bit output fields
	generate
		if (CW > 32) begin : g_wide
			assign count_o = (|count_q[CW-1:32]) ? '1 : count_q[31:0];
			assign line_o = (|line_q[CW-1:32]) ? '1 : line_q[31:0];
			assign col_o = (|col_q[CW-1:32]) ? '1 : col_q[31:0];
		end else begin : g_narrow
			assign count_o = 32'(count_q);
			assign line_o = 32'(line_q);
			assign col_o = 32'(col_q);
		end
	endgenerate

	// next state and result for the item in the input stage
	always_comb begin
		phase_d = phase_q;
		count_d = count_q;
		line_d = line_q;
		col_d = col_q;
		emit = 1'b0;
		res.event_kind = EV_TOKEN_BYTE;
		res.token_kind = TK_LABEL;
		res.token_byte = 8'h00;
		res.token_length = 32'h0;
		res.error_code = ERR_NONE;
		res.line_number = line_o;
		res.column_number = col_o;
		if (end_of_input) begin
			emit = 1'b1;
			if (phase_q == PH_SEQ && count_q != '0) begin
				res.event_kind = EV_TOKEN_DONE;
				res.token_kind = TK_SEQ;
				res.token_length = count_o;
			end else begin
				res.event_kind = EV_PARSE_DONE;
				case (phase_q)
					PH_ERR_LABEL: res.error_code = ERR_EMPTY_LABEL;
					PH_ERR_SEQ:   res.error_code = ERR_NO_SEQ;
					PH_ERR_CHAR:  res.error_code = ERR_BAD_CHAR;
					default:      res.error_code = ERR_NONE;
				endcase
			end
			phase_d = PH_START;
			count_d = '0;
			line_d = ONE;
			col_d = '0;
		end else begin
			// position tracking in every phase
			if (cls.is_lf) begin
				line_d = line_inc;
				col_d = '0;
			end else begin
				col_d = col_inc;
			end
			case (phase_q)
				PH_START: begin
					if (rec_start) begin
						phase_d = PH_LABEL;
					end
				end
				PH_LABEL: begin
					emit = 1'b1;
					if (cls.is_lf || cls.is_blank) begin
						if (count_q == '0) begin
							phase_d = PH_ERR_LABEL;
							res.event_kind = EV_SYNTAX_ERR;
							res.token_byte = in_byte;
							res.error_code = ERR_EMPTY_LABEL;
						end else begin
							res.event_kind = EV_TOKEN_DONE;
							res.token_length = count_o;
							count_d = '0;
							phase_d = cls.is_lf ? PH_SEQ : PH_COMMENT;
						end
					end else begin
						count_d = count_inc;
						res.token_byte = in_byte;
					end
				end
				PH_COMMENT: begin
					res.token_kind = TK_COMMENT;
					if (cls.is_lf) begin
						phase_d = PH_SEQ;
						if (count_q != '0) begin
							emit = 1'b1;
							res.event_kind = EV_TOKEN_DONE;
							res.token_length = count_o;
							count_d = '0;
						end
					end else begin
						emit = 1'b1;
						count_d = count_inc;
						res.token_byte = in_byte;
					end
				end
				PH_SEQ: begin
					if (rec_start) begin
						emit = 1'b1;
						if (count_q == '0) begin
							phase_d = PH_ERR_SEQ;
							res.event_kind = EV_SYNTAX_ERR;
							res.token_byte = in_byte;
							res.error_code = ERR_NO_SEQ;
						end else begin
							res.event_kind = EV_TOKEN_DONE;
							res.token_kind = TK_SEQ;
							res.token_length = count_o;
							count_d = '0;
							phase_d = PH_LABEL;
						end
					end else if (!cls.is_seq_ws) begin
						emit = 1'b1;
						if (cls.letter_ok) begin
							count_d = count_inc;
							res.token_kind = TK_SEQ;
							res.token_byte = in_byte;
						end else begin
							phase_d = PH_ERR_CHAR;
							res.event_kind = EV_SYNTAX_ERR;
							res.token_byte = in_byte;
							res.token_length = count_o;
							res.error_code = ERR_BAD_CHAR;
						end
					end
				end
				default: begin
					// stopped on an error: only position moves
				end
			endcase
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			count_q <= '0;
			line_q <= ONE;
			col_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			count_q <= count_d;
			line_q <= line_d;
			col_q <= col_d;
		end
	end

	// error phases hold until end of input
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == PH_ERR_LABEL || phase_q == PH_ERR_SEQ || phase_q == PH_ERR_CHAR) &&
		 !(fire && end_of_input)) |=> (phase_q == $past(phase_q)))
		else $error("error phase left without end of input");

	// end of input rearms the parser
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_of_input) |=>
		(phase_q == PH_START && count_q == '0 && line_q == ONE && col_q == '0))
		else $error("parser not rearmed after end of input");

	// no token is gathered before the first record
	a_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_START) |-> (count_q == '0))
		else $error("token length nonzero before first record");

endmodule

// ===== rtl/core/fasta_stream_tokenizer.sv =====
// FASTA text tokenizer, one byte per request.
// Input channel: s_tdata carries one text byte, s_tlast marks end of input
// (the byte is then ignored; any pending sequence token is closed, a parse
// done event otherwise, and the parser rearms to line 1, column 0).
// Output channel: zero or one result per input request. m_tuser holds the
// event kind and token kind, m_tdata the token byte, token length, error
// code, line and column.
// A request accepted into the input stage register is decoded there, and its
// result, if any, is loaded into the output register when that register is
// free; m_tvalid is driven by the output register.
// Throughput is one request per cycle while no result waits on a full output,
// set by the single decode step between the input and output registers.
// When the receiver stalls, the result waits in the output register and
// the input stage still takes one further request; requests that give
// no result keep flowing while the output is full.
// Reset rearms the parse state and counters and resets the alphabet register
// (DNA); the user must write it via the APB port only while idle, unenforced.
module fasta_stream_tokenizer
	import fst_pkg::*;
#(
	parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,  // [7:0] in_byte
	input  logic              s_tlast,  // end_of_input
	// output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [111:0]      m_tdata,  // [7:0] token_byte, [39:8] token_length,
	                                    // [41:40] error_code, [73:42] line_number,
	                                    // [105:74] column_number, rest zero
	output logic [3:0]        m_tuser   // [1:0] event_kind, [3:2] token_kind
);

	logic        alphabet_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        eoi_s1;
	logic        out_valid_q;
	result_t     out_res_q;
	byte_class_t cls;
	logic        emit;
	result_t     res;
	logic        out_free;
	logic        s1_adv;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_q <= ALPHA_DNA;
		end else if (psel && penable && pwrite && pready &&
			paddr[ADDR_W-1] == REG_ALPHABET) begin
			alphabet_q <= pwdata[0];
		end
	end
	assign prdata = (paddr[ADDR_W-1] == REG_ALPHABET) ? {31'h0, alphabet_q} : 32'h0;

	// stage flow control
	assign out_free = !out_valid_q || m_tready;
	assign s1_adv = valid_s1 && (!emit || out_free);
	assign s_tready = !valid_s1 || s1_adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eoi_s1 <= s_tlast;
		end
	end

	fst_class u_class (
		.in_byte         (byte_s1),
		.alphabet_select (alphabet_q),
		.cls             (cls)
	);

	fst_core #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (s1_adv),
		.in_byte      (byte_s1),
		.end_of_input (eoi_s1),
		.cls          (cls),
		.emit         (emit),
		.res          (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = {out_res_q.token_kind, out_res_q.event_kind};
	assign m_tdata = {6'h0, out_res_q.column_number, out_res_q.line_number,
		out_res_q.error_code, out_res_q.token_length, out_res_q.token_byte};

	// a blocked input stage keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> valid_s1)
		else $error("input stage request lost while blocked");

endmodule

// ===== tb/sv/tb_fasta_stream_tokenizer.sv =====
module tb_fasta_stream_tokenizer;
	import fst_pkg::*;

	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASE_ITEMS = 340;
	localparam int NUM_PHASES = 6;
	localparam logic [ADDR_W-1:0] ADDR_ALPHABET = {REG_ALPHABET, 2'b00};
	localparam logic [ADDR_W-1:0] ADDR_SPARE = {1'b1, 2'b00};

	// one text request: a byte or the end-of-input mark
	typedef struct packed {
		logic [7:0] chr;
		logic       eoi;
	} text_req_t;

	// parser shadow and store of the events still to come
	class token_event_board;
		logic        alphabet;
		logic [2:0]  phase;
		logic [31:0] tok_len;
		logic [31:0] line_no;
		logic [31:0] col_no;
		result_t     expected_events[$];
		int          mismatches;

		function new();
			alphabet = ALPHA_DNA;
			mismatches = 0;
			rearm();
		endfunction

		function void rearm();
			phase = PH_START;
			tok_len = '0;
			line_no = 32'd1;
			col_no = '0;
		endfunction

		function logic [31:0] bump(logic [31:0] v);
			return (v == '1) ? v : v + 32'd1;
		endfunction

		// letters of the selected alphabet in either case, and the gap mark
		function bit in_alphabet(logic [7:0] c);
			logic [7:0] u;
			u = c;
			if (c == CHR_DASH) begin
				return 1'b1;
			end
			if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
				u = c - CASE_OFFSET;
			end
			if (u < CHR_UPPER_A || u > CHR_UPPER_Z) begin
				return 1'b0;
			end
			if (alphabet == ALPHA_PROTEIN) begin
				return u != "J" && u != "O";
			end
			case (u)
				"A", "B", "C", "D", "G", "H", "K", "M",
				"N", "R", "S", "T", "V", "W", "X", "Y": return 1'b1;
				default: return 1'b0;
			endcase
		endfunction

		function result_t make_event(logic [1:0] ev, logic [1:0] kind, logic [7:0] chr,
				logic [31:0] len, logic [1:0] err, logic [31:0] ln, logic [31:0] cl);
			result_t r;
			r.event_kind = ev;
			r.token_kind = kind;
			r.token_byte = chr;
			r.token_length = len;
			r.error_code = err;
			r.line_number = ln;
			r.column_number = cl;
			return r;
		endfunction

		// accepted request: advance the shadow parser, queue any event
		function void note_byte(logic [7:0] c, logic eoi);
			result_t     r;
			logic [31:0] ln;
			logic [31:0] cl;
			logic [2:0]  ph;
			logic [1:0]  sticky;
			bit          emit;
			ln = line_no;
			cl = col_no;
			ph = phase;
			emit = 1'b0;
			r = '0;

			// end of input: flush a pending sequence or report the sticky error
			if (eoi) begin
				case (ph)
					PH_ERR_LABEL: sticky = ERR_EMPTY_LABEL;
					PH_ERR_SEQ: sticky = ERR_NO_SEQ;
					PH_ERR_CHAR: sticky = ERR_BAD_CHAR;
					default: sticky = ERR_NONE;
				endcase
				if (ph == PH_SEQ && tok_len != 0) begin
					r = make_event(EV_TOKEN_DONE, TK_SEQ, 8'h00, tok_len, ERR_NONE, ln, cl);
				end else begin
					r = make_event(EV_PARSE_DONE, TK_LABEL, 8'h00, '0, sticky, ln, cl);
				end
				expected_events.push_back(r);
				rearm();
				return;
			end

			// position tracking runs in every phase
			if (c == CHR_LF) begin
				line_no = bump(line_no);
				col_no = '0;
			end else begin
				col_no = bump(col_no);
			end

			// error events carry token kind zero, which is the label code
			case (ph)
				PH_START: begin
					if (c == CHR_GT && cl == 0) begin
						phase = PH_LABEL;
					end
				end
				PH_LABEL: begin
					emit = 1'b1;
					if (c == CHR_LF || c == CHR_SPACE || c == CHR_TAB) begin
						if (tok_len == 0) begin
							phase = PH_ERR_LABEL;
							r = make_event(EV_SYNTAX_ERR, TK_LABEL, c, '0, ERR_EMPTY_LABEL,
								ln, cl);
						end else begin
							r = make_event(EV_TOKEN_DONE, TK_LABEL, 8'h00, tok_len, ERR_NONE,
								ln, cl);
							tok_len = '0;
							phase = (c == CHR_LF) ? PH_SEQ : PH_COMMENT;
						end
					end else begin
						tok_len = bump(tok_len);
						r = make_event(EV_TOKEN_BYTE, TK_LABEL, c, '0, ERR_NONE, ln, cl);
					end
				end
				PH_COMMENT: begin
					if (c == CHR_LF) begin
						phase = PH_SEQ;
						if (tok_len != 0) begin
							r = make_event(EV_TOKEN_DONE, TK_COMMENT, 8'h00, tok_len, ERR_NONE,
								ln, cl);
							tok_len = '0;
							emit = 1'b1;
						end
					end else begin
						tok_len = bump(tok_len);
						r = make_event(EV_TOKEN_BYTE, TK_COMMENT, c, '0, ERR_NONE, ln, cl);
						emit = 1'b1;
					end
				end
				PH_SEQ: begin
					if (c == CHR_GT && cl == 0) begin
						emit = 1'b1;
						if (tok_len == 0) begin
							phase = PH_ERR_SEQ;
							r = make_event(EV_SYNTAX_ERR, TK_LABEL, c, '0, ERR_NO_SEQ, ln, cl);
						end else begin
							r = make_event(EV_TOKEN_DONE, TK_SEQ, 8'h00, tok_len, ERR_NONE,
								ln, cl);
							tok_len = '0;
							phase = PH_LABEL;
						end
					end else if (!(c == CHR_CR || c == CHR_LF || c == CHR_TAB
							|| c == CHR_SPACE)) begin
						emit = 1'b1;
						if (in_alphabet(c)) begin
							tok_len = bump(tok_len);
							r = make_event(EV_TOKEN_BYTE, TK_SEQ, c, '0, ERR_NONE, ln, cl);
						end else begin
							phase = PH_ERR_CHAR;
							r = make_event(EV_SYNTAX_ERR, TK_LABEL, c, tok_len, ERR_BAD_CHAR,
								ln, cl);
						end
					end
				end
				default: begin
				end
			endcase
			if (emit) begin
				expected_events.push_back(r);
			end
		endfunction

		function void report(string what, result_t e, result_t a);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%s: exp ev=%0d tk=%0d byte=%02h len=%0d err=%0d line=%0d col=%0d",
					what, e.event_kind, e.token_kind, e.token_byte, e.token_length,
					e.error_code, e.line_number, e.column_number);
				$display("    got ev=%0d tk=%0d byte=%02h len=%0d err=%0d line=%0d col=%0d",
					a.event_kind, a.token_kind, a.token_byte, a.token_length,
					a.error_code, a.line_number, a.column_number);
			end
		endfunction

		// accepted event against the oldest one waiting
		function void check_event(logic [111:0] data, logic [3:0] user);
			result_t a;
			result_t e;
			a.event_kind = user[1:0];
			a.token_kind = user[3:2];
			a.token_byte = data[7:0];
			a.token_length = data[39:8];
			a.error_code = data[41:40];
			a.line_number = data[73:42];
			a.column_number = data[105:74];
			if (expected_events.size() == 0) begin
				report("unexpected event", '0, a);
			end else begin
				e = expected_events.pop_front();
				if (a !== e) begin
					report("event mismatch", e, a);
				end
			end
		endfunction

		function void check_register(logic [31:0] value);
			if (value !== {31'b0, alphabet}) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("alphabet readback: exp %0d got %08h", alphabet, value);
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;  // [7:0] in_byte
	logic              s_tlast;  // end_of_input
	logic              m_tvalid;
	logic              m_tready;
	logic [111:0]      m_tdata;  // [7:0] token_byte, [39:8] token_length,
	                             // [41:40] error_code, [73:42] line_number,
	                             // [105:74] column_number, rest zero
	logic [3:0]        m_tuser;  // [1:0] event_kind, [3:2] token_kind

	token_event_board board = new();
	text_req_t        text_q[$];
	string            dna_letters = "ABCDGHKMNRSTVWXY";
	int               items_sent = 0;
	int               tx_calm = 0;
	int               rx_calm = 0;
	bit               hold_pending = 1'b0;

	fasta_stream_tokenizer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
	end

	always #1 clk = ~clk;

	// idle length: mostly none or short, now and then long, with calm stretches
	function automatic int idle_len(ref int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 99) < 2) begin
			calm = $urandom_range(30, 150);
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 50);
	endfunction

	// text building
	function void add_byte(logic [7:0] b);
		text_q.push_back(text_req_t'{b, 1'b0});
	endfunction

	function void add_eoi();
		text_q.push_back(text_req_t'{8'($urandom), 1'b1});
	endfunction

	function void add_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			add_byte(s[i]);
		end
	endfunction

	function logic [7:0] label_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom);
		end while (c == CHR_LF || c == CHR_SPACE || c == CHR_TAB);
		return c;
	endfunction

	function logic [7:0] comment_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom);
		end while (c == CHR_LF);
		return c;
	endfunction

	// sequence letter of the current alphabet, random case, with gaps and blanks
	function logic [7:0] seq_char();
		logic [7:0] u;
		int         r;
		r = $urandom_range(0, 29);
		if (r == 0) begin
			return CHR_DASH;
		end
		if (r == 1) begin
			return CHR_SPACE;
		end
		if (r == 2) begin
			return CHR_TAB;
		end
		if (board.alphabet == ALPHA_PROTEIN) begin
			do begin
				u = 8'($urandom_range(CHR_UPPER_A, CHR_UPPER_Z));
			end while (u == "J" || u == "O");
		end else begin
			u = dna_letters[$urandom_range(0, dna_letters.len() - 1)];
		end
		if ($urandom_range(0, 2) == 0) begin
			u = u + CASE_OFFSET;
		end
		return u;
	endfunction

	// one record: header line, optional comment, up to three sequence lines
	function void add_record();
		int n;
		int m;
		add_byte(CHR_GT);
		n = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6);
		repeat (n) add_byte(label_char());
		// end of input while a label is still open
		if ($urandom_range(0, 19) == 0) begin
			add_eoi();
			return;
		end
		if ($urandom_range(0, 2) == 0) begin
			add_byte($urandom_range(0, 1) ? CHR_SPACE : CHR_TAB);
			m = $urandom_range(0, 8);
			repeat (m) add_byte(comment_char());
		end
		add_byte(CHR_LF);
		n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
		repeat (n) begin
			m = $urandom_range(1, 16);
			repeat (m) add_byte(seq_char());
			// stray byte, usually outside the alphabet
			if ($urandom_range(0, 29) == 0) begin
				add_byte(8'($urandom));
			end
			if ($urandom_range(0, 3) == 0) begin
				add_byte(CHR_CR);
			end
			add_byte(CHR_LF);
		end
	endfunction

	// one text: mostly well-formed records, some plain noise
	function void add_file();
		int n;
		if ($urandom_range(0, 7) == 0) begin
			n = $urandom_range(5, 30);
			repeat (n) add_byte(8'($urandom));
			add_eoi();
			return;
		end
		if ($urandom_range(0, 5) == 0) begin
			n = $urandom_range(1, 4);
			repeat (n) add_byte(8'($urandom));
			add_byte(CHR_LF);
		end
		n = $urandom_range(1, 4);
		repeat (n) add_record();
		add_eoi();
	endfunction

	// register access: setup cycle, access cycle, then idle with select dropped
	task automatic cfg_access(input logic wr, input logic [ADDR_W-1:0] addr,
			input logic [31:0] wdata, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		while (!pready) @(negedge clk);
		rdata = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_config(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
		logic [31:0] rd;
		cfg_access(1'b1, addr, value, rd);
		if (addr == ADDR_ALPHABET) begin
			board.alphabet = value[0];
		end
		cfg_access(1'b0, ADDR_ALPHABET, '0, rd);
		board.check_register(rd);
	endtask

	task automatic send_request(input text_req_t req);
		int gap;
		gap = idle_len(tx_calm);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= req.chr;
		s_tlast <= req.eoi;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic play_text();
		text_req_t req;
		while (text_q.size() != 0) begin
			req = text_q.pop_front();
			send_request(req);
			items_sent++;
		end
	endtask

	// stop sending and wait for every outstanding event
	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.expected_events.size() != 0) @(posedge clk);
	endtask

	// drained, plus room for requests still in the pipe that give no event
	task automatic settle();
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// both handshakes sampled mid-cycle, ahead of the edge that takes them
	always @(negedge clk) begin
		if (s_tvalid && s_tready) begin
			board.note_byte(s_tdata, s_tlast);
		end
		if (m_tvalid && m_tready) begin
			board.check_event(m_tdata, m_tuser);
		end
	end

	// receiver pacing, with one long hold-off on request
	always begin : rx_pacing
		int n;
		@(posedge clk);
		if (hold_pending) begin
			m_tready <= 1'b0;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_pending = 1'b0;
			m_tready <= 1'b1;
		end else begin
			n = idle_len(rx_calm);
			if (n > 0) begin
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [31:0] rnd;
		logic        alpha;
		int          target;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed texts on DNA letters
		rnd = $urandom;
		write_config(ADDR_ALPHABET, {rnd[31:1], ALPHA_DNA});
		// stray bytes before the first record, label, comment, blanks, next record,
		// empty label by tab, bytes ignored after an error, end with sticky error
		add_text("x>\n>");
		add_byte(8'hFF);
		add_text(" c\na");
		add_byte(CHR_CR);
		add_text("-\n>\t");
		add_byte(8'h00);
		add_eoi();
		// missing sequence data
		add_text(">q\n>");
		add_eoi();
		// empty comment, then a letter outside the alphabet
		add_text(">r \ngE");
		add_eoi();
		// pending sequence flushed by end of input
		add_text(">k\nt");
		add_eoi();
		play_text();
		settle();

		// random texts over alternating alphabets
		for (int p = 1; p <= NUM_PHASES; p++) begin
			alpha = p[0] ? ALPHA_PROTEIN : ALPHA_DNA;
			if (p == 3) begin
				rnd = $urandom;
				write_config(ADDR_SPARE, rnd);
			end
			rnd = $urandom;
			write_config(ADDR_ALPHABET, {rnd[31:1], alpha});
			if (p == 2) begin
				// sender keeps going while the receiver holds off
				hold_pending = 1'b1;
				tx_calm = 400;
			end
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				add_file();
				play_text();
				if (p == 4 && items_sent >= target - PHASE_ITEMS / 2 && rx_calm >= 0) begin
					if (board.expected_events.size() != 0) begin
						drain();
					end
				end
			end
			settle();
		end

		if (board.mismatches == 0 && board.expected_events.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/fst_pkg.sv
rtl/core/fst_class.sv
rtl/core/fst_core.sv
rtl/core/fasta_stream_tokenizer.sv
tb/sv/tb_fasta_stream_tokenizer.sv
